FILE: rtl/particle_pool_integrator_assert.svh
// Assertion macros shared by the block's checker.
`ifndef PARTICLE_POOL_INTEGRATOR_ASSERT_SVH
`define PARTICLE_POOL_INTEGRATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PPI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PPI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/ppi_pkg.sv
// Shared constants, types and helpers for the particle pool integrator.
`default_nettype none
package ppi_pkg;
  localparam int unsigned MaxParticles = 64;
  localparam int unsigned TexCells     = 4;
  localparam logic [15:0] TimeStepRst  = 16'd1092;
  localparam logic [16:0] LifeOne      = 17'h10000;
  localparam logic [16:0] DecayMax     = 17'h1FFFF;

  localparam logic [1:0] OpAdd  = 2'd0;
  localparam logic [1:0] OpTick = 2'd1;
  localparam logic [1:0] OpDraw = 2'd2;
  localparam logic [1:0] OpNop  = 2'd3;

  localparam logic [1:0] KindVertex = 2'd0;
  localparam logic [1:0] KindAdded  = 2'd1;
  localparam logic [1:0] KindDrop   = 2'd2;

  // One pool entry as held in the memory.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [31:0] scol;
    logic [31:0] ecol;
    logic [31:0] size;
    logic [3:0]  tex;
    logic [16:0] life;
    logic [16:0] decay;
  } entry_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [33:0] mx;
    logic signed [33:0] mn;
    mx = 34'sh0_7FFF_FFFF;
    mn = -34'sh0_8000_0000;
    if (x > mx) sat32 = 32'sh7FFF_FFFF;
    else if (x < mn) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction

  // (s*L + e*(65536-L) + 32768) >> 16 on 16-bit operands.
  function automatic logic [16:0] blend(input logic [15:0] s, input logic [15:0] e,
                                        input logic [16:0] l);
    logic [33:0] acc;
    logic [16:0] il;
    il  = LifeOne - l;
    acc = {1'b0, s} * l + {1'b0, e} * il + 34'd32768;
    blend = acc[32:16];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/ppi_divider.sv
// Restoring divider for the decay rate: ceil(num / den), one bit a cycle.
`default_nettype none
module ppi_divider (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [23:0] num_i,
  input  wire  [15:0] den_i,
  output logic        done_o,
  output logic [16:0] quot_o
);
  logic [23:0] q_q, q_d;
  logic [16:0] r_q, r_d;
  logic [15:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [16:0] trial;
  logic [16:0] sh;

  always_comb begin
    sh    = {r_q[15:0], q_q[23]};
    trial = sh - {1'b0, den_q};
    q_d   = {q_q[22:0], 1'b0};
    r_d   = sh;
    if (sh >= {1'b0, den_q}) begin
      r_d   = trial;
      q_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd24;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  // quotient < 2^24; result saturates to 17 bits after rounding up
  logic [24:0] qc;
  assign qc = {1'b0, q_q} + {24'd0, (r_q != '0)};
  assign quot_o = (qc > 25'h1FFFF) ? ppi_pkg::DecayMax : qc[16:0];
endmodule
`default_nettype wire

FILE: rtl/ppi_integ.sv
// Integration of one axis: products registered, then sums, then clamped results.
`default_nettype none
module ppi_integ (
  input  wire                clk_i,
  input  wire                en1_i,
  input  wire                en2_i,
  input  wire                en3_i,
  input  wire  signed [31:0] p_i,
  input  wire  signed [31:0] v_i,
  input  wire  signed [31:0] a_i,
  input  wire         [15:0] dt_i,
  output logic signed [31:0] p_o,
  output logic signed [31:0] v_o
);
  logic signed [48:0] vdt_q, adt_q;
  logic signed [31:0] p1_q, v1_q, v2_q;
  logic signed [32:0] adt_s_q;
  logic signed [49:0] half_q;
  logic signed [33:0] p2_q;
  logic signed [33:0] psum, vsum;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      vdt_q <= v_i * $signed({1'b0, dt_i});
      adt_q <= a_i * $signed({1'b0, dt_i});
      p1_q  <= p_i;
      v1_q  <= v_i;
    end
    if (en2_i) begin
      adt_s_q <= adt_q[48:16];
      half_q  <= $signed(adt_q[48:16]) * $signed({1'b0, dt_i});
      p2_q    <= {{2{p1_q[31]}}, p1_q} + {vdt_q[48], vdt_q[48:16]};
      v2_q    <= v1_q;
    end
  end

  // p + vdt + half stays within 34 bits; clamp only once at the end
  always_comb begin
    psum = p2_q + {half_q[49], half_q[49:17]};
    vsum = {{2{v2_q[31]}}, v2_q} + {adt_s_q[32], adt_s_q};
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      p_o <= ppi_pkg::sat32(psum);
      v_o <= ppi_pkg::sat32(vsum);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/particle_pool_integrator.sv
// Particle pool integrator: add, tick and draw over a pool held in one memory.
// Input channel (in_valid_i/in_stall_o) carries one command: add, tick or draw.
// Output channel (out_valid_o/out_stall_i) carries result items from one register.
// Add: the result waits for the bit-serial decay divider; when the lifetime is
// zero or the pool is full it is registered at the transfer.  One result.
// Tick: each particle in turn is read from the pool memory, taken through the
// three-stage integrator and written back in S_TRD, S_T1, S_T2, S_T3 and S_TWR;
// no result.
// Draw: each particle is read in S_DRD and S_DWT; S_OUT holds while the receiver
// stalls; one vertex each, the last flagged.  One command is worked on at a time.
// The user must write time_step through cfg_we_i/cfg_wdata_i only while idle;
// the block does not enforce this.  Reset empties the pool and loads time_step
// with one sixtieth of a second; the memory itself is not cleared.  A stalling
// receiver holds the output register, the input stalls and the sequencer waits.
`default_nettype none
module particle_pool_integrator #(
  parameter int unsigned MAX_PARTICLES = ppi_pkg::MaxParticles,
  parameter int unsigned TEX_CELLS     = ppi_pkg::TexCells
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  opcode_i,
  input  wire  [31:0] pos_x_i,
  input  wire  [31:0] pos_y_i,
  input  wire  [31:0] vel_x_i,
  input  wire  [31:0] vel_y_i,
  input  wire  [31:0] acc_x_i,
  input  wire  [31:0] acc_y_i,
  input  wire  [15:0] lifetime_i,
  input  wire  [31:0] size_pair_i,
  input  wire  [31:0] start_color_i,
  input  wire  [31:0] end_color_i,
  input  wire  [1:0]  tex_index_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_vel_x_o,
  output logic [31:0] out_vel_y_o,
  output logic [31:0] out_color_o,
  output logic [15:0] out_size_o,
  output logic [1:0]  out_tex_o,
  output logic        last_o
);
  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_TRD, S_T1, S_T2, S_T3, S_TWR, S_DRD, S_DWT, S_OUT
  } state_e;

  state_e state_q;
  logic [15:0] ts_q;
  logic [CW-1:0] cnt_q, idx_q, wr_q;
  ppi_pkg::entry_t mem [MAX_PARTICLES];
  ppi_pkg::entry_t rd_q, hold_q, new_q;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  ppi_pkg::entry_t wdata;
  logic            div_start, div_done;
  logic [16:0]     div_q;
  logic signed [31:0] npx, npy, nvx, nvy;
  logic en1, en2, en3;
  logic last_in;
  logic out_load;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  ppi_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({ts_q, 8'd0}), .den_i(lifetime_i),
    .done_o(div_done), .quot_o(div_q)
  );

  assign en1 = (state_q == S_T1);
  assign en2 = (state_q == S_T2);
  assign en3 = (state_q == S_T3);

  // rd_q holds the entry being ticked in S_T1
  ppi_integ u_ix (.clk_i, .en1_i(en1), .en2_i(en2), .en3_i(en3),
    .p_i(rd_q.px), .v_i(rd_q.vx), .a_i(rd_q.ax), .dt_i(ts_q),
    .p_o(npx), .v_o(nvx));
  ppi_integ u_iy (.clk_i, .en1_i(en1), .en2_i(en2), .en3_i(en3),
    .p_i(rd_q.py), .v_i(rd_q.vy), .a_i(rd_q.ay), .dt_i(ts_q),
    .p_o(npy), .v_o(nvy));

  assign div_start = (state_q == S_IDLE) && in_valid_i && !in_stall_o
                     && opcode_i == ppi_pkg::OpAdd && cnt_q < CW'(MAX_PARTICLES)
                     && lifetime_i != 16'd0;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_o && out_stall_i);
  assign raddr = idx_q[AW-1:0];
  assign last_in = (idx_q + CW'(1) == cnt_q);

  // Cycles in which the output register takes a new result.
  assign out_load = ((state_q == S_IDLE) && in_valid_i && !in_stall_o
                     && opcode_i == ppi_pkg::OpAdd && !div_start)
                    || (state_q == S_DIV && div_done)
                    || (state_q == S_OUT && (!out_valid_o || !out_stall_i));

  // Tex index wrap by compare and subtract; the index is below four.
  function automatic logic [3:0] tex_wrap(input logic [1:0] t);
    logic [3:0] w;
    w = {2'b00, t};
    for (int k = 0; k < 3; k++) begin
      if ({28'd0, w} >= TEX_CELLS) w = w - 4'(TEX_CELLS);
    end
    tex_wrap = w;
  endfunction

  logic [16:0] l_sz, l_c0, l_c1, l_c2, l_c3;
  always_comb begin
    we    = 1'b0;
    waddr = wr_q[AW-1:0];
    wdata = new_q;
    if (state_q == S_DIV && div_done) begin
      we = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata.decay = div_q;
    end else if (state_q == S_IDLE && in_valid_i && !in_stall_o
                 && opcode_i == ppi_pkg::OpAdd && cnt_q < CW'(MAX_PARTICLES)
                 && lifetime_i == 16'd0) begin
      we = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata.px = pos_x_i; wdata.py = pos_y_i;
      wdata.vx = vel_x_i; wdata.vy = vel_y_i;
      wdata.ax = acc_x_i; wdata.ay = acc_y_i;
      wdata.scol = start_color_i; wdata.ecol = end_color_i;
      wdata.size = size_pair_i;
      wdata.tex = tex_wrap(tex_index_i);
      wdata.life = ppi_pkg::LifeOne; wdata.decay = ppi_pkg::DecayMax;
    end else if (state_q == S_TWR && hold_q.decay < hold_q.life) begin
      we = 1'b1;
      wdata = hold_q;
      wdata.px = npx; wdata.py = npy; wdata.vx = nvx; wdata.vy = nvy;
      wdata.life = hold_q.life - hold_q.decay;
    end
    l_sz = ppi_pkg::blend(rd_q.size[15:0], rd_q.size[31:16], rd_q.life);
    l_c0 = ppi_pkg::blend({8'd0, rd_q.scol[31:24]}, {8'd0, rd_q.ecol[31:24]}, rd_q.life);
    l_c1 = ppi_pkg::blend({8'd0, rd_q.scol[23:16]}, {8'd0, rd_q.ecol[23:16]}, rd_q.life);
    l_c2 = ppi_pkg::blend({8'd0, rd_q.scol[15:8]}, {8'd0, rd_q.ecol[15:8]}, rd_q.life);
    l_c3 = ppi_pkg::blend({8'd0, rd_q.scol[7:0]}, {8'd0, rd_q.ecol[7:0]}, rd_q.life);
  end

  function automatic logic [7:0] sat8(input logic [16:0] x);
    sat8 = (x > 17'd255) ? 8'hFF : x[7:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ts_q <= ppi_pkg::TimeStepRst;
      cnt_q <= '0; idx_q <= '0; wr_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) ts_q <= cfg_wdata_i;
      if (out_load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            unique case (opcode_i)
              ppi_pkg::OpAdd: begin
                kind_o <= (cnt_q < CW'(MAX_PARTICLES)) ? ppi_pkg::KindAdded
                                                      : ppi_pkg::KindDrop;
                out_pos_x_o <= '0; out_pos_y_o <= '0;
                out_vel_x_o <= '0; out_vel_y_o <= '0;
                out_color_o <= '0; out_size_o <= '0; out_tex_o <= '0;
                last_o <= 1'b1;
                new_q.px <= pos_x_i; new_q.py <= pos_y_i;
                new_q.vx <= vel_x_i; new_q.vy <= vel_y_i;
                new_q.ax <= acc_x_i; new_q.ay <= acc_y_i;
                new_q.scol <= start_color_i; new_q.ecol <= end_color_i;
                new_q.size <= size_pair_i;
                new_q.tex <= tex_wrap(tex_index_i);
                new_q.life <= ppi_pkg::LifeOne;
                new_q.decay <= ppi_pkg::DecayMax;
                if (div_start) state_q <= S_DIV;
                else if (cnt_q < CW'(MAX_PARTICLES)) cnt_q <= cnt_q + CW'(1);
              end
              ppi_pkg::OpTick: begin
                idx_q <= '0; wr_q <= '0;
                if (cnt_q != '0) state_q <= S_TRD;
              end
              ppi_pkg::OpDraw: begin
                idx_q <= '0;
                if (cnt_q != '0) state_q <= S_DRD;
              end
              default: ;
            endcase
          end
        end
        S_DIV: if (div_done) begin
          cnt_q <= cnt_q + CW'(1);
          state_q <= S_IDLE;
        end
        S_TRD: state_q <= S_T1;
        S_T1: begin hold_q <= rd_q; state_q <= S_T2; end
        S_T2: state_q <= S_T3;
        S_T3: state_q <= S_TWR;
        S_TWR: begin
          if (hold_q.decay < hold_q.life) wr_q <= wr_q + CW'(1);
          if (last_in) begin
            cnt_q <= (hold_q.decay < hold_q.life) ? wr_q + CW'(1) : wr_q;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + CW'(1);
            state_q <= S_TRD;
          end
        end
        S_DRD: state_q <= S_DWT;
        S_DWT: state_q <= S_OUT;
        S_OUT: if (!out_valid_o || !out_stall_i) begin
          kind_o <= ppi_pkg::KindVertex;
          out_pos_x_o <= rd_q.px; out_pos_y_o <= rd_q.py;
          out_vel_x_o <= rd_q.vx; out_vel_y_o <= rd_q.vy;
          out_color_o <= {sat8(l_c0), sat8(l_c1), sat8(l_c2), sat8(l_c3)};
          out_size_o <= l_sz[15:0] | {16{l_sz[16]}};
          out_tex_o <= rd_q.tex[1:0];
          last_o <= last_in;
          if (last_in) state_q <= S_IDLE;
          else begin
            idx_q <= idx_q + CW'(1);
            state_q <= S_DRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ppi_checker.sv
// Port-level checker for the particle pool integrator, bound to the top level.
`default_nettype none
`include "particle_pool_integrator_assert.svh"
module ppi_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  kind_o,
  input wire        last_o,
  input wire [31:0] out_pos_x_o
);
  `PPI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_pos_x_o) && $stable(kind_o))
  `PPI_ASSERT_IMP(a_kind_ok, clk_i, rst_ni, out_valid_o, kind_o == ppi_pkg::KindVertex || kind_o == ppi_pkg::KindAdded || kind_o == ppi_pkg::KindDrop)
  `PPI_ASSERT_IMP(a_add_last, clk_i, rst_ni, out_valid_o && kind_o != ppi_pkg::KindVertex, last_o)
  `PPI_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o)
endmodule

bind particle_pool_integrator ppi_checker u_ppi_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .kind_o, .last_o, .out_pos_x_o
);
`default_nettype wire

FILE: sim/particle_pool_integrator_tb.sv
// Self-checking testbench for the particle pool integrator: predicts every result and compares.
module particle_pool_integrator_tb;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] col;
    logic [15:0] size;
    logic [1:0]  tex;
    logic        last;
  } vertex_t;

  typedef struct {
    longint px, py, vx, vy, ax, ay;
    logic [31:0] scol, ecol, size;
    logic [1:0]  tex;
    int unsigned life, decay;
  } particle_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = ppi_pkg::OpTick;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic [31:0] acc_x_i = '0, acc_y_i = '0;
  logic [15:0] lifetime_i = 16'd1;
  logic [31:0] size_pair_i = '0, start_color_i = '0, end_color_i = '0;
  logic [1:0] tex_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [31:0] out_pos_x_o, out_pos_y_o, out_vel_x_o, out_vel_y_o, out_color_o;
  logic [15:0] out_size_o;
  logic [1:0] out_tex_o;
  logic last_o;

  particle_pool_integrator u_dut (.*);

  always #5 clk_i = ~clk_i;

  vertex_t     pending_vertices[$];
  particle_t   pool[$];
  int unsigned step_len = ppi_pkg::TimeStepRst;
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          steady_rx = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("error: %s got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint floor_sh(input longint x, input int k);
    return x >>> k;
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint sext(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic int unsigned mix(input int unsigned s, input int unsigned e,
                                      input int unsigned l, input int unsigned cap);
    longint unsigned r;
    r = (longint'(s) * l + longint'(e) * (65536 - l) + 32768) >> 16;
    return r > cap ? cap : int'(r);
  endfunction

  task automatic advance(inout longint p, inout longint v, input longint a);
    longint vdt, adt, half, dt;
    dt = longint'(step_len);
    vdt = floor_sh(v * dt, 16);
    adt = floor_sh(a * dt, 16);
    half = floor_sh(adt * dt, 17);
    p = clamp32(p + vdt + half);
    v = clamp32(v + adt);
  endtask

  task automatic predict(input logic [1:0] op, input particle_t np, input logic [15:0] lt);
    vertex_t r;
    particle_t q;
    particle_t kept[$];
    int unsigned d;
    r = '{default: '0};
    r.last = 1'b1;
    if (op == ppi_pkg::OpAdd) begin
      if (pool.size() >= ppi_pkg::MaxParticles) r.kind = ppi_pkg::KindDrop;
      else begin
        if (lt == 16'd0) d = ppi_pkg::DecayMax;
        else d = ((step_len << 8) + lt - 1) / lt;
        np.decay = d > ppi_pkg::DecayMax ? ppi_pkg::DecayMax : d;
        np.life = ppi_pkg::LifeOne;
        np.tex = np.tex % ppi_pkg::TexCells;
        pool = {pool, np};
        r.kind = ppi_pkg::KindAdded;
      end
      pending_vertices = {pending_vertices, r};
    end else if (op == ppi_pkg::OpTick) begin
      foreach (pool[i]) begin
        q = pool[i];
        advance(q.px, q.vx, q.ax);
        advance(q.py, q.vy, q.ay);
        if (q.decay < q.life) begin
          q.life -= q.decay;
          kept = {kept, q};
        end
      end
      pool = kept;
    end else if (op == ppi_pkg::OpDraw) begin
      foreach (pool[i]) begin
        q = pool[i];
        r.kind = ppi_pkg::KindVertex;
        r.px = q.px[31:0];
        r.py = q.py[31:0];
        r.vx = q.vx[31:0];
        r.vy = q.vy[31:0];
        for (int k = 0; k < 4; k++)
          r.col[24-8*k +: 8] = mix(q.scol[24-8*k +: 8], q.ecol[24-8*k +: 8], q.life, 255);
        r.size = mix(q.size[15:0], q.size[31:16], q.life, 16'hFFFF);
        r.tex = q.tex;
        r.last = (i == pool.size() - 1);
        pending_vertices = {pending_vertices, r};
      end
    end
  endtask

  // One transfer on the input channel, then the prediction.
  task automatic send(input logic [1:0] op, input particle_t np, input logic [15:0] lt);
    opcode_i <= op;
    pos_x_i <= np.px[31:0];
    pos_y_i <= np.py[31:0];
    vel_x_i <= np.vx[31:0];
    vel_y_i <= np.vy[31:0];
    acc_x_i <= np.ax[31:0];
    acc_y_i <= np.ay[31:0];
    lifetime_i <= lt;
    size_pair_i <= np.size;
    start_color_i <= np.scol;
    end_color_i <= np.ecol;
    tex_index_i <= np.tex;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict(op, np, lt);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_step(input logic [15:0] v);
    go_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    step_len = v;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rnd_particle();
    particle_t p;
    p.px = sext(rnd_word()); p.py = sext(rnd_word());
    p.vx = sext(rnd_word()); p.vy = sext(rnd_word());
    p.ax = sext(rnd_word()); p.ay = sext(rnd_word());
    p.size = $urandom; p.scol = $urandom; p.ecol = $urandom;
    p.tex = $urandom_range(0, 3);
    p.life = 0; p.decay = 0;
    return p;
  endfunction

  function automatic logic [15:0] rnd_life();
    return $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(1, 2000));
  endfunction

  // Bursts with gaps; a draw is sent every so often so vertices keep flowing.
  task automatic send_mix(input int n);
    int burst;
    int r;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 12);
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 55) send(ppi_pkg::OpAdd, rnd_particle(), rnd_life());
      else if (r < 80) send(ppi_pkg::OpTick, rnd_particle(), rnd_life());
      else if (r < 97) send(ppi_pkg::OpDraw, rnd_particle(), rnd_life());
      else send(ppi_pkg::OpNop, rnd_particle(), rnd_life());
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    particle_t p;
    p = rnd_particle();
    p.px = 64'sh7FFF_FFFF; p.vx = 64'sh7FFF_FFFF; p.ax = 64'sh7FFF_FFFF;
    p.py = -64'sh8000_0000; p.vy = -64'sh8000_0000; p.ay = -64'sh8000_0000;
    p.scol = 32'hFFFF_FFFF; p.ecol = 32'h0; p.size = 32'h0000_FFFF; p.tex = 2'd3;
    send(ppi_pkg::OpDraw, p, 16'd1);
    send(ppi_pkg::OpAdd, p, 16'hFFFF);
    p.px = 0; p.vx = 0; p.ax = 0; p.py = 0; p.vy = 0; p.ay = 0;
    p.scol = 32'h0; p.ecol = 32'hFFFF_FFFF; p.size = 32'hFFFF_0000; p.tex = 2'd0;
    send(ppi_pkg::OpAdd, p, 16'd1);
    send(ppi_pkg::OpAdd, rnd_particle(), 16'd60);
    // zero lifetime: saturated decay, gone at the first tick
    send(ppi_pkg::OpAdd, rnd_particle(), 16'd0);
    send(ppi_pkg::OpDraw, p, 16'd1);
    send(ppi_pkg::OpTick, p, 16'd1);
    send(ppi_pkg::OpDraw, p, 16'd1);
    send(ppi_pkg::OpNop, p, 16'd1);
    send(ppi_pkg::OpTick, p, 16'd1);
    send(ppi_pkg::OpDraw, p, 16'd1);
  endtask

  task automatic test_step_zero();
    set_step(16'd0);
    send(ppi_pkg::OpAdd, rnd_particle(), 16'd5);
    send(ppi_pkg::OpTick, rnd_particle(), 16'd5);
    send(ppi_pkg::OpDraw, rnd_particle(), 16'd5);
    set_step(16'hFFFF);
    send(ppi_pkg::OpAdd, rnd_particle(), 16'hFFFF);
    send(ppi_pkg::OpTick, rnd_particle(), 16'd1);
    send(ppi_pkg::OpDraw, rnd_particle(), 16'd1);
  endtask

  // Fill beyond capacity with the receiver held off, then drain.
  task automatic test_full_pool();
    set_step(16'd1);
    hold_off = 1'b1;
    for (int i = 0; i < ppi_pkg::MaxParticles + 4; i++)
      send(ppi_pkg::OpAdd, rnd_particle(), 16'hFFFF);
    hold_off = 1'b0;
    send(ppi_pkg::OpDraw, rnd_particle(), 16'd1);
    send(ppi_pkg::OpTick, rnd_particle(), 16'd1);
    send(ppi_pkg::OpDraw, rnd_particle(), 16'd1);
    go_idle();
  endtask

  task automatic test_random();
    set_step(ppi_pkg::TimeStepRst);
    send_mix(100);
    set_step(16'($urandom_range(1, 65535)));
    send_mix(90);
    steady_rx = 1'b1;
    set_step(16'd1);
    send_mix(90);
    steady_rx = 1'b0;
    go_idle();
  endtask

  // Receiver stall pattern, with a long hold-off while hold_off is set.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold++;
        out_stall_i <= (hold < 300);
      end else if (steady_rx) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    vertex_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_vertices.size() == 0) report("unexpected result kind", kind_o, 0);
      else begin
        w = pending_vertices.pop_front();
        if (kind_o !== w.kind) report("kind", kind_o, w.kind);
        if (out_pos_x_o !== w.px) report("pos_x", out_pos_x_o, w.px);
        if (out_pos_y_o !== w.py) report("pos_y", out_pos_y_o, w.py);
        if (out_vel_x_o !== w.vx) report("vel_x", out_vel_x_o, w.vx);
        if (out_vel_y_o !== w.vy) report("vel_y", out_vel_y_o, w.vy);
        if (out_color_o !== w.col) report("color", out_color_o, w.col);
        if (out_size_o !== w.size) report("size", out_size_o, w.size);
        if (out_tex_o !== w.tex) report("tex", out_tex_o, w.tex);
        if (last_o !== w.last) report("last", last_o, w.last);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !in_valid_i
        && pending_vertices.size() == 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("particle_pool_integrator: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_step_zero();
    test_full_pool();
    test_random();
    if (errors == 0 && pending_vertices.size() == 0) begin
      $display("particle_pool_integrator: match");
    end else begin
      $display("particle_pool_integrator: mismatch");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/ppi_pkg.sv
rtl/ppi_divider.sv
rtl/ppi_integ.sv
rtl/particle_pool_integrator.sv
rtl/ppi_checker.sv
sim/particle_pool_integrator_tb.sv
